// ----- rtl/core/srp_pkg.sv -----
// Shared types and constants for the shelf rectangle packer.
// Holds the input and result beat structs, the command and status codes
// and the configuration register indexes. Depends on nothing.
package srp_pkg;

  // Widths of the fixed fields and the running state.
  localparam int unsigned SIDE_W  = 8;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned NEED_W  = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // The shelf pen row saturates at the top of its 13-bit range.
  localparam int unsigned PEN_Y_MAX = 8191;

  // Register values after reset.
  localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST    = 13'd1024;
  localparam logic [DIM_W-1:0] INITIAL_HEIGHT_RST = 13'd512;

  // Command carried by an input beat.
  typedef enum logic [1:0] {
    KIND_PLACE = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Status reported by a result beat.
  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOROOM    = 3'd2,
    ST_NOROOM_FB = 3'd3,
    ST_FLUSHED   = 3'd4,
    ST_CLEAN     = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATLAS_WIDTH    = 2'd0,
    CFG_INITIAL_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SIDE_W-1:0] rect_width;
    logic [SIDE_W-1:0] rect_height;
    logic              is_fallback_glyph;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [DIM_W-1:0]   current_height;
    logic               grew;
    logic [DIM_W-1:0]   range_first;
    logic [DIM_W-1:0]   range_end;
  } out_item_t;

endpackage

// ----- rtl/core/shelf_rectangle_packer_top.sv -----
// Top level of the shelf rectangle packer: beat registers, packer state
// and configuration registers around the placement logic.
// Depends on srp_pkg and srp_core.

// The packer takes one command beat per clock while in_stall_o is low (place a
// cell, flush the dirty row range, or clear) and returns exactly one result
// beat for each, in order. A beat is held in an input register, the placement
// logic in srp_core works it out against the shelf and atlas state, and the
// state and the result register load together as the beat moves on, and a new
// command can follow every cycle while out_stall_i is low. While a result
// waits under out_stall_i one more command is taken into the input register;
// after that in_stall_o rises. Configuration writes are always ready and must
// only be issued while no command is in flight; a write to initial_height also
// restarts packing at that height.
module shelf_rectangle_packer_top #(
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  srp_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output srp_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srp_pkg::DIM_W-1:0]         cfg_data_i
);

  // Height and dirty range width: enough for the cap and for a cell end row.
  localparam int unsigned CAP_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HW    = (CAP_W > srp_pkg::NEED_W) ? CAP_W : srp_pkg::NEED_W;

  logic                       in_valid_q;
  srp_pkg::in_item_t          in_item_q;
  logic                       out_valid_q;
  srp_pkg::out_item_t         out_item_q;
  logic                       advance;
  logic                       cfg_we;

  logic [srp_pkg::DIM_W-1:0]  atlas_width_q;
  logic [srp_pkg::DIM_W-1:0]  pen_x_q;
  logic [srp_pkg::DIM_W-1:0]  pen_x_d;
  logic [srp_pkg::DIM_W-1:0]  pen_y_q;
  logic [srp_pkg::DIM_W-1:0]  pen_y_d;
  logic [srp_pkg::SIDE_W-1:0] shelf_h_q;
  logic [srp_pkg::SIDE_W-1:0] shelf_h_d;
  logic [HW-1:0]              atlas_h_q;
  logic [HW-1:0]              atlas_h_d;
  logic [HW-1:0]              dirty_first_q;
  logic [HW-1:0]              dirty_first_d;
  logic [HW-1:0]              dirty_end_q;
  logic [HW-1:0]              dirty_end_d;
  srp_pkg::out_item_t         result_d;

  // The held beat moves on whenever the result register is free or draining.
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Input beat register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  srp_core #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .HW        (HW)
  ) u_core (
    .item_i       (in_item_q),
    .atlas_width_i(atlas_width_q),
    .pen_x_i      (pen_x_q),
    .pen_y_i      (pen_y_q),
    .shelf_h_i    (shelf_h_q),
    .atlas_h_i    (atlas_h_q),
    .dirty_first_i(dirty_first_q),
    .dirty_end_i  (dirty_end_q),
    .pen_x_o      (pen_x_d),
    .pen_y_o      (pen_y_d),
    .shelf_h_o    (shelf_h_d),
    .atlas_h_o    (atlas_h_d),
    .dirty_first_o(dirty_first_d),
    .dirty_end_o  (dirty_end_d),
    .result_o     (result_d)
  );

  // Result beat register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  // Packer state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q <= srp_pkg::ATLAS_WIDTH_RST;
      pen_x_q       <= '0;
      pen_y_q       <= '0;
      shelf_h_q     <= '0;
      atlas_h_q     <= HW'(srp_pkg::INITIAL_HEIGHT_RST);
      dirty_first_q <= '0;
      dirty_end_q   <= HW'(srp_pkg::INITIAL_HEIGHT_RST);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        srp_pkg::CFG_ATLAS_WIDTH: begin
          atlas_width_q <= cfg_data_i;
        end
        srp_pkg::CFG_INITIAL_HEIGHT: begin
          // A new starting height also restarts packing.
          pen_x_q       <= '0;
          pen_y_q       <= '0;
          shelf_h_q     <= '0;
          atlas_h_q     <= HW'(cfg_data_i);
          dirty_first_q <= '0;
          dirty_end_q   <= HW'(cfg_data_i);
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      pen_x_q       <= pen_x_d;
      pen_y_q       <= pen_y_d;
      shelf_h_q     <= shelf_h_d;
      atlas_h_q     <= atlas_h_d;
      dirty_first_q <= dirty_first_d;
      dirty_end_q   <= dirty_end_d;
    end
  end

`ifndef SYNTH
  // The input side stalls only behind a held beat and a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // A held command beat that moves on reaches the result register next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced beat did not produce a result");

  // Growth always raises the atlas height.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && result_d.grew && !cfg_we) |=> (atlas_h_q > $past(atlas_h_q)))
    else $error("atlas growth did not raise the height");

  // Writing the starting height restarts the shelves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && cfg_index_i == srp_pkg::CFG_INITIAL_HEIGHT)
    |=> (pen_x_q == '0 && pen_y_q == '0 && shelf_h_q == '0 && dirty_first_q == '0))
    else $error("height write did not restart packing");
`endif

endmodule

// ----- rtl/core/srp_grow.sv -----
// Atlas height growth search for the shelf rectangle packer.
// Finds the first doubled height, capped at MAX_HEIGHT, that holds a cell.
// Depends on nothing but its parameters.
module srp_grow #(
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned HW         = 14
) (
  input  logic [HW-1:0] height_i,
  input  logic [HW-1:0] need_i,
  output logic          fits_o,
  output logic          grew_o,
  output logic [HW-1:0] height_o
);

  // Doublings from a height of one that always reach the cap.
  localparam int unsigned K  = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = HW + K;

  logic [HW-1:0] base;

  // A zero height steps to one before it starts doubling.
  assign base = (height_i == '0) ? HW'(1) : height_i;

  // Every candidate height is compared in parallel; the smallest that fits wins.
  always_comb begin
    logic [WW-1:0] shifted;
    logic [HW-1:0] cand;
    logic          any;
    logic [HW-1:0] sel;
    any     = 1'b0;
    sel     = HW'(MAX_HEIGHT);
    shifted = '0;
    cand    = '0;
    for (int k = K; k >= 1; k--) begin
      shifted = WW'(base) << k;
      cand    = (shifted > WW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : shifted[HW-1:0];
      if (cand >= need_i) begin
        sel = cand;
        any = 1'b1;
      end
    end

    if (height_i >= HW'(MAX_HEIGHT)) begin
      // At or above the cap the atlas never grows.
      fits_o   = (need_i <= height_i);
      grew_o   = 1'b0;
      height_o = height_i;
    end else if (need_i <= height_i) begin
      fits_o   = 1'b1;
      grew_o   = 1'b0;
      height_o = height_i;
    end else begin
      // Growth is kept even when the cell still does not fit at the cap.
      fits_o   = any;
      grew_o   = 1'b1;
      height_o = sel;
    end
  end

endmodule

// ----- rtl/core/srp_core.sv -----
// Single-pass placement logic of the shelf rectangle packer.
// Maps one command beat and the packer state to the next state and a result.
// Depends on srp_pkg and srp_grow.
module srp_core #(
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned HW         = 14
) (
  input  srp_pkg::in_item_t                 item_i,
  input  logic [srp_pkg::DIM_W-1:0]         atlas_width_i,
  input  logic [srp_pkg::DIM_W-1:0]         pen_x_i,
  input  logic [srp_pkg::DIM_W-1:0]         pen_y_i,
  input  logic [srp_pkg::SIDE_W-1:0]        shelf_h_i,
  input  logic [HW-1:0]                     atlas_h_i,
  input  logic [HW-1:0]                     dirty_first_i,
  input  logic [HW-1:0]                     dirty_end_i,
  output logic [srp_pkg::DIM_W-1:0]         pen_x_o,
  output logic [srp_pkg::DIM_W-1:0]         pen_y_o,
  output logic [srp_pkg::SIDE_W-1:0]        shelf_h_o,
  output logic [HW-1:0]                     atlas_h_o,
  output logic [HW-1:0]                     dirty_first_o,
  output logic [HW-1:0]                     dirty_end_o,
  output srp_pkg::out_item_t                result_o
);

  localparam int unsigned NW = srp_pkg::NEED_W;

  logic [srp_pkg::SIDE_W-1:0] w;
  logic [srp_pkg::SIDE_W-1:0] h;
  logic [NW-1:0]              aw_ext;
  logic                       too_wide;
  logic                       wrap;
  logic [NW-1:0]              py_sum;
  logic [srp_pkg::DIM_W-1:0]  px1;
  logic [srp_pkg::DIM_W-1:0]  py1;
  logic [srp_pkg::SIDE_W-1:0] sh1;
  logic [HW-1:0]              need;
  logic [HW-1:0]              py_end;
  logic                       fits;
  logic                       grew;
  logic [HW-1:0]              grown_h;

  assign w      = item_i.rect_width;
  assign h      = item_i.rect_height;
  assign aw_ext = NW'(atlas_width_i);

  // The cell plus its gap must fit across the atlas at all.
  assign too_wide = (NW'(w) + NW'(1)) > aw_ext;

  // Open a new shelf under the tallest cell when the current one is full.
  assign wrap   = (NW'(pen_x_i) + NW'(w) + NW'(1)) > aw_ext;
  assign py_sum = NW'(pen_y_i) + NW'(shelf_h_i) + NW'(1);
  assign px1    = wrap ? '0 : pen_x_i;
  assign sh1    = wrap ? '0 : shelf_h_i;
  assign py1    = !wrap ? pen_y_i
                : (py_sum > NW'(srp_pkg::PEN_Y_MAX)) ? srp_pkg::DIM_W'(srp_pkg::PEN_Y_MAX)
                : py_sum[srp_pkg::DIM_W-1:0];

  // Rows the cell and its gap below need, and the row after the cell.
  assign py_end = HW'(py1) + HW'(h);
  assign need   = py_end + HW'(1);

  srp_grow #(
    .MAX_HEIGHT(MAX_HEIGHT),
    .HW        (HW)
  ) u_grow (
    .height_i(atlas_h_i),
    .need_i  (need),
    .fits_o  (fits),
    .grew_o  (grew),
    .height_o(grown_h)
  );

  // Next state and result for the command.
  always_comb begin
    logic [HW-1:0] df_g;
    logic [HW-1:0] de_g;
    df_g          = grew ? '0 : dirty_first_i;
    de_g          = grew ? grown_h : dirty_end_i;
    pen_x_o       = pen_x_i;
    pen_y_o       = pen_y_i;
    shelf_h_o     = shelf_h_i;
    atlas_h_o     = atlas_h_i;
    dirty_first_o = dirty_first_i;
    dirty_end_o   = dirty_end_i;
    result_o      = '0;
    result_o.status = srp_pkg::ST_EMPTY;

    case (srp_pkg::kind_e'(item_i.kind))
      srp_pkg::KIND_PLACE: begin
        if (w == '0 || h == '0) begin
          result_o.status = srp_pkg::ST_EMPTY;
        end else if (too_wide) begin
          result_o.status = item_i.is_fallback_glyph ? srp_pkg::ST_NOROOM_FB
                                                     : srp_pkg::ST_NOROOM;
        end else begin
          // A new shelf and any growth stand even if the cell is refused.
          pen_x_o       = px1;
          pen_y_o       = py1;
          shelf_h_o     = sh1;
          atlas_h_o     = grown_h;
          dirty_first_o = df_g;
          dirty_end_o   = de_g;
          result_o.grew = grew;
          if (fits) begin
            result_o.status = srp_pkg::ST_PLACED;
            result_o.pos_x  = px1[srp_pkg::COORD_W-1:0];
            result_o.pos_y  = py1[srp_pkg::COORD_W-1:0];
            dirty_first_o   = (HW'(py1) < df_g) ? HW'(py1) : df_g;
            dirty_end_o     = (py_end > de_g) ? py_end : de_g;
            pen_x_o         = px1 + srp_pkg::DIM_W'(w) + srp_pkg::DIM_W'(1);
            shelf_h_o       = (h > sh1) ? h : sh1;
          end else begin
            result_o.status = item_i.is_fallback_glyph ? srp_pkg::ST_NOROOM_FB
                                                       : srp_pkg::ST_NOROOM;
          end
        end
      end
      srp_pkg::KIND_FLUSH: begin
        if (dirty_end_i <= dirty_first_i) begin
          result_o.status = srp_pkg::ST_CLEAN;
        end else begin
          result_o.status      = srp_pkg::ST_FLUSHED;
          result_o.range_first = dirty_first_i[srp_pkg::DIM_W-1:0];
          result_o.range_end   = dirty_end_i[srp_pkg::DIM_W-1:0];
          dirty_first_o        = atlas_h_i;
          dirty_end_o          = '0;
        end
      end
      srp_pkg::KIND_CLEAR: begin
        pen_x_o         = '0;
        pen_y_o         = '0;
        shelf_h_o       = '0;
        dirty_first_o   = '0;
        dirty_end_o     = atlas_h_i;
        result_o.status = srp_pkg::ST_CLEARED;
      end
      default: begin
        result_o.status = srp_pkg::ST_EMPTY;
      end
    endcase

    result_o.current_height = atlas_h_o[srp_pkg::DIM_W-1:0];
  end

endmodule

// ----- verif/tb_shelf_rectangle_packer_top.sv -----
// Self-checking testbench for shelf_rectangle_packer_top.
// Runs a directed script, then random commands under several register settings and
// idle patterns. Each result is checked against a shelf packing predictor or a written-out result. Uses srp_pkg.
module tb_shelf_rectangle_packer_top;

  localparam int unsigned MAX_H       = 4096;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          SETTLE_CYC  = 4;
  localparam int          TAIL_CYC    = 8;
  localparam int          PHASES      = 8;
  localparam int          PHASE_BEATS = 150;
  localparam int          ANY_VALUE   = -1;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  // Ports of the block.
  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  srp_pkg::in_item_t             in_item_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  srp_pkg::out_item_t            out_item_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [srp_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [srp_pkg::DIM_W-1:0]     cfg_data_i;

  // One line of the directed script: a register write or a repeated command beat.
  typedef struct {
    bit                        is_cfg;
    srp_pkg::cfg_idx_e         idx;
    logic [srp_pkg::DIM_W-1:0] data;
    srp_pkg::in_item_t         beat;
    int                        reps;
    bit                        fixed;
    srp_pkg::out_item_t        want;
  } script_row_t;

  // Shelf and atlas state as the predictor sees it.
  logic [srp_pkg::DIM_W-1:0]  width_r;
  logic [srp_pkg::DIM_W-1:0]  pen_x_r;
  logic [srp_pkg::DIM_W-1:0]  pen_y_r;
  logic [srp_pkg::SIDE_W-1:0] shelf_h_r;
  logic [srp_pkg::DIM_W-1:0]  atlas_h_r;
  logic [srp_pkg::DIM_W-1:0]  dirty_lo_r;
  logic [srp_pkg::DIM_W-1:0]  dirty_hi_r;

  srp_pkg::out_item_t owed_replies_q[$];
  srp_pkg::out_item_t next_reply;
  srp_pkg::out_item_t want_reply;
  script_row_t        script_rows[$];

  // Typed expectation that rides along with a directed beat.
  bit                 row_fixed;
  srp_pkg::out_item_t row_want;

  int send_gap_pct;
  int recv_stall_pct;
  int fault_count;
  int shown;
  int beats_taken;
  int cfg_writes;
  int grew_seen;
  int seen_status[8];

  shelf_rectangle_packer_top #(
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Packing restarts at the top-left corner with the whole atlas dirty.
  function automatic void restart_shelves();
    pen_x_r    = '0;
    pen_y_r    = '0;
    shelf_h_r  = '0;
    dirty_lo_r = '0;
    dirty_hi_r = atlas_h_r;
  endfunction

  // Applies one command to the predicted state and returns the result beat it causes.
  function automatic srp_pkg::out_item_t atlas_step(srp_pkg::in_item_t b);
    srp_pkg::out_item_t r;
    int unsigned        w;
    int unsigned        h;
    int unsigned        nh;
    int unsigned        ny;
    logic               fits;
    r        = '0;
    r.status = srp_pkg::ST_EMPTY;
    w        = 32'(b.rect_width);
    h        = 32'(b.rect_height);
    fits     = 1'b1;
    case (b.kind)
      srp_pkg::KIND_PLACE: begin
        if (w == 0 || h == 0) begin
          r.status = srp_pkg::ST_EMPTY;
        end else if (w + 1 > width_r) begin
          r.status = b.is_fallback_glyph ? srp_pkg::ST_NOROOM_FB : srp_pkg::ST_NOROOM;
        end else begin
          // Open a new shelf under the tallest cell when the current one is full.
          if (pen_x_r + w + 1 > width_r) begin
            ny        = pen_y_r + shelf_h_r + 1;
            pen_x_r   = '0;
            pen_y_r   = srp_pkg::DIM_W'((ny > srp_pkg::PEN_Y_MAX) ? srp_pkg::PEN_Y_MAX : ny);
            shelf_h_r = '0;
          end
          // Double the atlas until the cell fits or the cap stops it.
          while (fits && (pen_y_r + h + 1 > atlas_h_r)) begin
            if (atlas_h_r >= MAX_H) begin
              fits = 1'b0;
            end else begin
              nh = atlas_h_r * 2;
              if (nh == 0) nh = 1;
              if (nh > MAX_H) nh = MAX_H;
              atlas_h_r  = srp_pkg::DIM_W'(nh);
              dirty_lo_r = '0;
              dirty_hi_r = srp_pkg::DIM_W'(nh);
              r.grew     = 1'b1;
            end
          end
          if (!fits) begin
            r.status = b.is_fallback_glyph ? srp_pkg::ST_NOROOM_FB : srp_pkg::ST_NOROOM;
          end else begin
            r.status = srp_pkg::ST_PLACED;
            r.pos_x  = pen_x_r[srp_pkg::COORD_W-1:0];
            r.pos_y  = pen_y_r[srp_pkg::COORD_W-1:0];
            if (pen_y_r < dirty_lo_r) dirty_lo_r = pen_y_r;
            if (pen_y_r + h > dirty_hi_r) dirty_hi_r = srp_pkg::DIM_W'(pen_y_r + h);
            pen_x_r = srp_pkg::DIM_W'(pen_x_r + w + 1);
            if (h > shelf_h_r) shelf_h_r = b.rect_height;
          end
        end
      end
      srp_pkg::KIND_FLUSH: begin
        if (dirty_hi_r <= dirty_lo_r) begin
          r.status = srp_pkg::ST_CLEAN;
        end else begin
          r.status      = srp_pkg::ST_FLUSHED;
          r.range_first = dirty_lo_r;
          r.range_end   = dirty_hi_r;
          dirty_lo_r    = atlas_h_r;
          dirty_hi_r    = '0;
        end
      end
      srp_pkg::KIND_CLEAR: begin
        restart_shelves();
        r.status = srp_pkg::ST_CLEARED;
      end
      default: begin
        r.status = srp_pkg::ST_EMPTY;
      end
    endcase
    r.current_height = atlas_h_r;
    return r;
  endfunction

  // Script rows: a command checked by the predictor, a command with its result
  // written out, and a register write.
  function automatic script_row_t beat_row(logic [1:0] k, int w, int h, bit fb, int reps = 1);
    script_row_t r;
    r.is_cfg                 = 1'b0;
    r.idx                    = srp_pkg::CFG_ATLAS_WIDTH;
    r.data                   = '0;
    r.beat                   = '0;
    r.fixed                  = 1'b0;
    r.want                   = '0;
    r.beat.kind              = k;
    r.beat.rect_width        = w[srp_pkg::SIDE_W-1:0];
    r.beat.rect_height       = h[srp_pkg::SIDE_W-1:0];
    r.beat.is_fallback_glyph = fb;
    r.reps                   = reps;
    return r;
  endfunction

  function automatic script_row_t fixed_row(logic [1:0] k, int w, int h, bit fb,
                                            srp_pkg::status_e st, int px, int py, int ht,
                                            int rf, int re);
    script_row_t r;
    r                     = beat_row(k, w, h, fb);
    r.fixed               = 1'b1;
    r.want.status         = st;
    r.want.pos_x          = px[srp_pkg::COORD_W-1:0];
    r.want.pos_y          = py[srp_pkg::COORD_W-1:0];
    r.want.current_height = ht[srp_pkg::DIM_W-1:0];
    r.want.grew           = 1'b0;
    r.want.range_first    = rf[srp_pkg::DIM_W-1:0];
    r.want.range_end      = re[srp_pkg::DIM_W-1:0];
    return r;
  endfunction

  function automatic script_row_t reg_row(srp_pkg::cfg_idx_e idx, int val);
    script_row_t r;
    r        = beat_row(KIND_UNUSED, 0, 0, 1'b0);
    r.reps   = 0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = val[srp_pkg::DIM_W-1:0];
    return r;
  endfunction

  // Drives one command beat from a falling edge and holds it until it is taken.
  task automatic send_beat(srp_pkg::in_item_t b, bit fixed, srp_pkg::out_item_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = b;
    row_fixed  = fixed;
    row_want   = want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Registers change only once every result is back and the pipeline is empty.
  task automatic settle();
    in_valid_i = 1'b0;
    while (owed_replies_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(srp_pkg::cfg_idx_e idx, logic [srp_pkg::DIM_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver side: stall pattern picked anew each cycle.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Sample every handshake at the rising edge, check results and advance the predictor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        if (cfg_index_i == srp_pkg::CFG_ATLAS_WIDTH) begin
          width_r = cfg_data_i;
        end else if (cfg_index_i == srp_pkg::CFG_INITIAL_HEIGHT) begin
          atlas_h_r = cfg_data_i;
          restart_shelves();
        end
      end
      // Results are checked before this edge's command is added to the queue.
      if (out_valid_o && !out_stall_i) begin
        if (owed_replies_q.size() == 0) begin
          fault_count++;
          if (shown < 10) $display("unexpected result beat: status %0d", out_item_o.status);
          shown++;
        end else begin
          want_reply = owed_replies_q.pop_front();
          seen_status[out_item_o.status]++;
          if (out_item_o.grew === 1'b1) grew_seen++;
          if (out_item_o.status         !== want_reply.status ||
              out_item_o.pos_x          !== want_reply.pos_x ||
              out_item_o.pos_y          !== want_reply.pos_y ||
              out_item_o.current_height !== want_reply.current_height ||
              out_item_o.grew           !== want_reply.grew ||
              out_item_o.range_first    !== want_reply.range_first ||
              out_item_o.range_end      !== want_reply.range_end) begin
            fault_count++;
            if (shown < 10) begin
              $display("mismatch (expected/actual): status %0d/%0d pos %0d,%0d/%0d,%0d",
                       want_reply.status, out_item_o.status, want_reply.pos_x,
                       want_reply.pos_y, out_item_o.pos_x, out_item_o.pos_y);
              $display("  height %0d/%0d grew %0d/%0d range %0d-%0d/%0d-%0d",
                       want_reply.current_height, out_item_o.current_height,
                       want_reply.grew, out_item_o.grew, want_reply.range_first,
                       want_reply.range_end, out_item_o.range_first, out_item_o.range_end);
            end
            shown++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        beats_taken++;
        next_reply = atlas_step(in_item_i);
        owed_replies_q.push_back(row_fixed ? row_want : next_reply);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Stimulus: directed script, then random phases.
  initial begin
    int                 cfg_w[PHASES];
    int                 cfg_h[PHASES];
    int                 p;
    int                 n;
    int                 r;
    int                 val;
    srp_pkg::in_item_t  b;
    srp_pkg::out_item_t none;
    cfg_w = '{1024, 4096, 1, 300, ANY_VALUE, 64, 2, ANY_VALUE};
    cfg_h = '{512, 1, 4096, 64, ANY_VALUE, 4096, 0, ANY_VALUE};
    none           = '0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = srp_pkg::CFG_ATLAS_WIDTH;
    cfg_data_i     = '0;
    row_fixed      = 1'b0;
    row_want       = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    fault_count    = 0;
    shown          = 0;
    beats_taken    = 0;
    cfg_writes     = 0;
    grew_seen      = 0;
    seen_status    = '{default: 0};
    width_r        = srp_pkg::ATLAS_WIDTH_RST;
    atlas_h_r      = srp_pkg::INITIAL_HEIGHT_RST;
    restart_shelves();

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset state, empty cells, the unused command, flush and clear.
    script_rows.push_back(fixed_row(srp_pkg::KIND_FLUSH, 0, 0, 0,
                                    srp_pkg::ST_FLUSHED, 0, 0, 512, 0, 512));
    script_rows.push_back(fixed_row(srp_pkg::KIND_FLUSH, 0, 0, 0,
                                    srp_pkg::ST_CLEAN, 0, 0, 512, 0, 0));
    script_rows.push_back(fixed_row(srp_pkg::KIND_PLACE, 0, 5, 0,
                                    srp_pkg::ST_EMPTY, 0, 0, 512, 0, 0));
    script_rows.push_back(fixed_row(srp_pkg::KIND_PLACE, 5, 0, 1,
                                    srp_pkg::ST_EMPTY, 0, 0, 512, 0, 0));
    script_rows.push_back(fixed_row(KIND_UNUSED, 255, 255, 1,
                                    srp_pkg::ST_EMPTY, 0, 0, 512, 0, 0));
    script_rows.push_back(fixed_row(srp_pkg::KIND_PLACE, 255, 255, 0,
                                    srp_pkg::ST_PLACED, 0, 0, 512, 0, 0));
    script_rows.push_back(fixed_row(srp_pkg::KIND_FLUSH, 0, 0, 0,
                                    srp_pkg::ST_FLUSHED, 0, 0, 512, 0, 255));
    script_rows.push_back(beat_row(srp_pkg::KIND_PLACE, 255, 255, 1));
    script_rows.push_back(fixed_row(srp_pkg::KIND_CLEAR, 0, 0, 0,
                                    srp_pkg::ST_CLEARED, 0, 0, 512, 0, 0));
    // A cell wider than the atlas is refused at once, with both refusal codes.
    script_rows.push_back(reg_row(srp_pkg::CFG_ATLAS_WIDTH, 255));
    script_rows.push_back(fixed_row(srp_pkg::KIND_PLACE, 255, 1, 0,
                                    srp_pkg::ST_NOROOM, 0, 0, 512, 0, 0));
    script_rows.push_back(fixed_row(srp_pkg::KIND_PLACE, 255, 1, 1,
                                    srp_pkg::ST_NOROOM_FB, 0, 0, 512, 0, 0));
    script_rows.push_back(beat_row(srp_pkg::KIND_PLACE, 254, 255, 1));
    // Growth from a zero-height atlas, then a climb of full shelves up to the cap.
    script_rows.push_back(reg_row(srp_pkg::CFG_ATLAS_WIDTH, 2));
    script_rows.push_back(reg_row(srp_pkg::CFG_INITIAL_HEIGHT, 0));
    script_rows.push_back(beat_row(srp_pkg::KIND_PLACE, 1, 255, 0, 17));
    script_rows.push_back(beat_row(srp_pkg::KIND_PLACE, 1, 1, 1));
    // Both registers at 4096, the height cap MAX_H.
    script_rows.push_back(reg_row(srp_pkg::CFG_ATLAS_WIDTH, 4096));
    script_rows.push_back(reg_row(srp_pkg::CFG_INITIAL_HEIGHT, 4096));
    script_rows.push_back(beat_row(srp_pkg::KIND_PLACE, 255, 255, 0));
    script_rows.push_back(beat_row(srp_pkg::KIND_FLUSH, 0, 0, 0));
    script_rows.push_back(beat_row(srp_pkg::KIND_CLEAR, 0, 0, 0));

    foreach (script_rows[i]) begin
      if (script_rows[i].is_cfg) begin
        settle();
        write_reg(script_rows[i].idx, script_rows[i].data);
      end else begin
        repeat (script_rows[i].reps)
          send_beat(script_rows[i].beat, script_rows[i].fixed, script_rows[i].want);
      end
    end

    // Random phases: new register values and a new idle pattern each time.
    for (p = 0; p < PHASES; p++) begin
      settle();
      val = (cfg_w[p] == ANY_VALUE) ? $urandom_range(1, 4096) : cfg_w[p];
      write_reg(srp_pkg::CFG_ATLAS_WIDTH, srp_pkg::DIM_W'(val));
      val = (cfg_h[p] == ANY_VALUE) ? $urandom_range(1, 4096) : cfg_h[p];
      write_reg(srp_pkg::CFG_INITIAL_HEIGHT, srp_pkg::DIM_W'(val));
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 70; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 70; end
        default: begin send_gap_pct = 34; recv_stall_pct = 34; end
      endcase
      for (n = 0; n < PHASE_BEATS; n++) begin
        b.rect_width        = srp_pkg::SIDE_W'($urandom_range(0, 255));
        b.rect_height       = srp_pkg::SIDE_W'($urandom_range(0, 255));
        b.is_fallback_glyph = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        // Mostly placements, with flushes, rare clears and a few odd commands.
        if (r < 82) begin
          b.kind = srp_pkg::KIND_PLACE;
          r = $urandom_range(0, 99);
          if (r < 35) b.rect_width = srp_pkg::SIDE_W'($urandom_range(1, 24));
          else if (r < 50) b.rect_width = srp_pkg::SIDE_W'($urandom_range(200, 255));
          if ($urandom_range(0, 1)) b.rect_height = srp_pkg::SIDE_W'($urandom_range(96, 255));
        end else if (r < 92) begin
          b.kind = srp_pkg::KIND_FLUSH;
        end else if (r < 94) begin
          b.kind = srp_pkg::KIND_CLEAR;
        end else if (r < 97) begin
          b.kind = KIND_UNUSED;
        end else begin
          b.kind = srp_pkg::KIND_PLACE;
          if ($urandom_range(0, 1)) b.rect_width = '0;
          else b.rect_height = '0;
        end
        send_beat(b, 1'b0, none);
      end
    end

    // Drain, then idle for the tail to show any stray beat.
    in_valid_i     = 1'b0;
    send_gap_pct   = 0;
    while (owed_replies_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYC) @(negedge clk_i);
    if (owed_replies_q.size() != 0) fault_count++;

    $display("summary: %0d commands, %0d register writes, %0d placed, %0d refused, %0d grew",
             beats_taken, cfg_writes, seen_status[srp_pkg::ST_PLACED],
             seen_status[srp_pkg::ST_NOROOM] + seen_status[srp_pkg::ST_NOROOM_FB], grew_seen);
    $display("summary: %0d flushed, %0d already clean, %0d cleared, %0d empty, %0d faults",
             seen_status[srp_pkg::ST_FLUSHED], seen_status[srp_pkg::ST_CLEAN],
             seen_status[srp_pkg::ST_CLEARED], seen_status[srp_pkg::ST_EMPTY], fault_count);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/srp_pkg.sv
rtl/core/srp_grow.sv
rtl/core/srp_core.sv
rtl/core/shelf_rectangle_packer_top.sv
verif/tb_shelf_rectangle_packer_top.sv
